// ===== hw/rtl/bwaar_pkg.sv =====
// Shared types, constants and register codes for the bitmap area-average resampler.
// Used by every module of the block; no dependencies.
package bwaar_pkg;

    localparam int ROW_CELLS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_SRC_W_DEF = 32;
    localparam int MAX_SRC_H_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [5:0]  SRC_WIDTH_RST  = 6'd1;
    localparam logic [5:0]  SRC_HEIGHT_RST = 6'd1;
    localparam logic [20:0] INV_SCALE_RST  = 21'd65536;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_INV_SCALE  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SCAN  = 2'd1,
        CMD_MISS  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [5:0]  src_width;
        logic [5:0]  src_height;
        logic [20:0] inv_scale;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [4:0]             row_idx;
        logic [ROW_CELLS-1:0]   row_bits;
        logic [4:0]             y_lo;
        logic [4:0]             y_hi;
        logic [ROW_CELLS-1:0]   mask;
        logic [10:0]            total;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hw/rtl/bitmap_area_average_resample_unit.sv =====
// Bitmap area-average resampler: a query passes front and queue, then the back reads its R
// footprint rows in the source (1 to 32), none on a source miss; a row write is stored when
// the back pops it. The back reads one bitmap row per cycle from one memory read port and
// may still serve a query while the front takes the next; writes one per cycle while the
// queue has room and the front is idle. Reset clears control state, sets width 1, height 1,
// inverse scale 1.0; the bitmap is not cleared and holds no defined value until written.
module bitmap_area_average_resample_unit
    import bwaar_pkg::*;
#(
    parameter int MAX_SRC_W = MAX_SRC_W_DEF,
    parameter int MAX_SRC_H = MAX_SRC_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [4:0]  i_row_index,
    input  logic [31:0] i_row_bits,
    input  logic [9:0]  i_out_x,
    input  logic [9:0]  i_out_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_lit
);

    t_cfg    r_cfg;
    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= SRC_WIDTH_RST;
            r_cfg.src_height <= SRC_HEIGHT_RST;
            r_cfg.inv_scale  <= INV_SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[5:0];
                CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[5:0];
                CFG_INV_SCALE:  r_cfg.inv_scale  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bwaar_front #(
        .MAX_SRC_W (MAX_SRC_W),
        .MAX_SRC_H (MAX_SRC_H)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_out_x     (i_out_x),
        .i_out_y     (i_out_y),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    bwaar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    bwaar_back #(
        .MAX_SRC_W (MAX_SRC_W),
        .MAX_SRC_H (MAX_SRC_H)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_lit       (o_lit)
    );

endmodule

// ===== hw/rtl/bwaar_queue.sv =====
// Short command queue between the front and back parts of the resampler.
// Depends on bwaar_pkg for the command and status types.
module bwaar_queue
    import bwaar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_cmd        = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");

endmodule

// ===== hw/rtl/bwaar_front.sv =====
// Front part: accepts items, maps query footprints through the inverse scale and
// clips them to the source. Depends on bwaar_pkg.
module bwaar_front
    import bwaar_pkg::*;
#(
    parameter int MAX_SRC_W = MAX_SRC_W_DEF,
    parameter int MAX_SRC_H = MAX_SRC_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [4:0]  i_row_index,
    input  logic [31:0] i_row_bits,
    input  logic [9:0]  i_out_x,
    input  logic [9:0]  i_out_y,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int RW = (MAX_SRC_W < ROW_CELLS) ? MAX_SRC_W : ROW_CELLS;
    localparam int RH = (MAX_SRC_H < ROW_CELLS) ? MAX_SRC_H : ROW_CELLS;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MX,
        F_MY,
        F_FY,
        F_CL
    } t_state;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] hi;
        logic [5:0]  span;
        logic        empty;
    } t_span;

    function automatic t_span calc_span(input logic [31:0] prod, input logic [20:0] inv);
        t_span       s;
        logic [31:0] b_up;
        logic [15:0] fend;
        logic [15:0] diff;
        b_up    = prod + {11'd0, inv} + 32'h0000_FFFF;
        fend    = b_up[31:FRAC_BITS];
        s.first = prod[31:FRAC_BITS];
        s.empty = (fend <= s.first);
        s.hi    = fend - 16'd1;
        diff    = fend - s.first;
        s.span  = diff[5:0];
        return s;
    endfunction

    t_state        r_state;
    t_state        n_state;
    logic [9:0]    r_ox;
    logic [9:0]    r_oy;
    logic [31:0]   r_prod;
    t_span         r_x;
    t_span         r_y;

    logic [9:0]    mul_o;
    logic [30:0]   mul_p;
    logic [5:0]    w;
    logic [5:0]    h;
    logic          scan;
    logic [5:0]    cx_hi;
    logic [5:0]    cy_hi;
    logic [ROW_CELLS-1:0] mask;
    logic [10:0]   total;
    logic          is_write;

    assign mul_o    = (r_state == F_MX) ? r_ox : r_oy;
    assign mul_p    = mul_o * i_cfg.inv_scale;
    assign is_write = (t_op'(i_operation) == OP_WRITE);

    always_comb begin
        w = (i_cfg.src_width > 6'(RW)) ? 6'(RW) : i_cfg.src_width;
        h = (i_cfg.src_height > 6'(RH)) ? 6'(RH) : i_cfg.src_height;
        scan = !r_x.empty && !r_y.empty && (w != 6'd0) && (h != 6'd0) &&
               (r_x.first < {10'd0, w}) && (r_y.first < {10'd0, h});
        cx_hi = (r_x.hi < {10'd0, w}) ? r_x.hi[5:0] : w - 6'd1;
        cy_hi = (r_y.hi < {10'd0, h}) ? r_y.hi[5:0] : h - 6'd1;
        for (int i = 0; i < ROW_CELLS; i++) begin
            mask[i] = (16'(i) >= r_x.first) && (6'(i) <= cx_hi);
        end
        total = {5'd0, r_x.span} * {5'd0, r_y.span};
    end

    assign o_in_ready = (r_state == F_IDLE) && !i_q_stat.full;
    assign o_push     = (o_in_ready && i_in_valid && is_write) ||
                        ((r_state == F_CL) && !i_q_stat.full);

    always_comb begin
        o_cmd = '0;
        if (r_state == F_IDLE) begin
            o_cmd.kind     = CMD_WRITE;
            o_cmd.row_idx  = i_row_index;
            o_cmd.row_bits = i_row_bits;
        end else begin
            o_cmd.kind  = scan ? CMD_SCAN : CMD_MISS;
            o_cmd.y_lo  = r_y.first[4:0];
            o_cmd.y_hi  = cy_hi[4:0];
            o_cmd.mask  = mask;
            o_cmd.total = total;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (o_in_ready && i_in_valid && !is_write) begin
                    n_state = F_MX;
                end
            end
            F_MX: n_state = F_MY;
            F_MY: n_state = F_FY;
            F_FY: n_state = F_CL;
            F_CL: begin
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            F_IDLE: begin
                r_ox <= i_out_x;
                r_oy <= i_out_y;
            end
            F_MX: begin
                r_prod <= {1'b0, mul_p};
            end
            F_MY: begin
                r_x    <= calc_span(r_prod, i_cfg.inv_scale);
                r_prod <= {1'b0, mul_p};
            end
            F_FY: begin
                r_y <= calc_span(r_prod, i_cfg.inv_scale);
            end
            default: begin
            end
        endcase
    end

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (r_state == F_CL) && scan) |->
            (o_cmd.y_lo <= o_cmd.y_hi) && (o_cmd.mask != '0))
        else $error("scan command with empty row range or mask");

endmodule

// ===== hw/rtl/bwaar_back.sv =====
// Back part: holds the source bitmap, stores rows and scans footprint rows with a
// masked popcount, then thresholds the coverage. Depends on bwaar_pkg.
module bwaar_back
    import bwaar_pkg::*;
#(
    parameter int MAX_SRC_W = MAX_SRC_W_DEF,
    parameter int MAX_SRC_H = MAX_SRC_H_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_lit
);

    localparam int RW = (MAX_SRC_W < ROW_CELLS) ? MAX_SRC_W : ROW_CELLS;
    localparam int RH = (MAX_SRC_H < ROW_CELLS) ? MAX_SRC_H : ROW_CELLS;
    localparam int AW = (RH > 1) ? $clog2(RH) : 1;
    localparam int COV_LIT_WEIGHT   = 50;
    localparam int COV_TOTAL_WEIGHT = 21;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD,
        B_DRAIN,
        B_CMP,
        B_OUT
    } t_state;

    function automatic logic [5:0] popcount(input logic [RW-1:0] v);
        logic [5:0] c;
        c = 6'd0;
        for (int i = 0; i < RW; i++) begin
            c = c + 6'(v[i]);
        end
        return c;
    endfunction

    logic [RW-1:0] mem [RH];
    logic [RW-1:0] r_rdata;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_last;
    logic [RW-1:0] r_mask;
    logic [10:0]   r_total;
    logic [10:0]   r_acc;
    logic          r_rd_vld;
    logic          r_lit;

    assign o_pop       = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_out_valid = (r_state == B_OUT);
    assign o_lit       = r_lit;

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == CMD_WRITE) && ({1'b0, i_cmd.row_idx} < 6'(RH))) begin
            mem[i_cmd.row_idx[AW-1:0]] <= i_cmd.row_bits[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_RD) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.kind)
                        CMD_SCAN: n_state = B_RD;
                        CMD_MISS: n_state = B_OUT;
                        default:  n_state = B_IDLE;
                    endcase
                end
            end
            B_RD: begin
                if (r_addr == r_last) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: n_state = B_CMP;
            B_CMP:   n_state = B_OUT;
            B_OUT: begin
                if (i_out_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == B_RD);
        end
        if (r_rd_vld) begin
            r_acc <= r_acc + {5'd0, popcount(r_rdata & r_mask)};
        end
        case (r_state)
            B_IDLE: begin
                r_addr  <= i_cmd.y_lo[AW-1:0];
                r_last  <= i_cmd.y_hi[AW-1:0];
                r_mask  <= i_cmd.mask[RW-1:0];
                r_total <= i_cmd.total;
                r_acc   <= '0;
                r_lit   <= 1'b0;
            end
            B_RD: begin
                if (r_addr != r_last) begin
                    r_addr <= r_addr + AW'(1);
                end
            end
            B_CMP: begin
                r_lit <= (17'(r_acc) * 17'(COV_LIT_WEIGHT)) >
                         (17'(r_total) * 17'(COV_TOTAL_WEIGHT));
            end
            default: begin
            end
        endcase
    end

    a_lit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CMP) |-> (r_acc <= r_total))
        else $error("lit count exceeds footprint total");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for bitmap_area_average_resample_unit: directed and random row writes and
// pixel queries over several scale and size settings, each lit result checked in order.
// Depends on bwaar_pkg and the unit's RTL.
module testbench;
    import bwaar_pkg::*;

    localparam logic [1:0] CFG_UNUSED_IDX  = 2'd3;
    localparam int         BITMAP_ROWS     = 32;
    localparam int         SETTLE_CYCLES   = 48;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 54;

    class coverage_scoreboard;
        bit [31:0] rows [BITMAP_ROWS];
        bit        written [BITMAP_ROWS];
        bit [5:0]  width  = SRC_WIDTH_RST;
        bit [5:0]  height = SRC_HEIGHT_RST;
        bit [20:0] inv    = INV_SCALE_RST;
        bit        expected_lit [$];
        int        fails;

        function void set_register(logic [1:0] idx, logic [20:0] data);
            case (idx)
                CFG_SRC_WIDTH:  width  = data[5:0];
                CFG_SRC_HEIGHT: height = data[5:0];
                CFG_INV_SCALE:  inv    = data;
                default: ;
            endcase
        endfunction

        function bit axis_span(longint unsigned o, output longint unsigned lo,
                               output longint unsigned hi);
            longint unsigned first;
            longint unsigned stop;
            first = (o * inv) >> FRAC_BITS;
            stop  = ((o + 1) * inv + (64'd1 << FRAC_BITS) - 1) >> FRAC_BITS;
            lo = first;
            hi = stop - 1;
            return stop > first;
        endfunction

        function longint unsigned clip_size(bit [5:0] v, int bound);
            longint unsigned s;
            s = v;
            if (s > bound) s = bound;
            if (s > ROW_CELLS) s = ROW_CELLS;
            return s;
        endfunction

        // Footprint total, and the part of it that lies in the source, if any.
        function bit source_window(bit [9:0] x, bit [9:0] y,
                                   output longint unsigned xl, output longint unsigned xh,
                                   output longint unsigned yl, output longint unsigned yh,
                                   output longint unsigned total);
            longint unsigned w;
            longint unsigned h;
            total = 0;
            if (!axis_span(x, xl, xh) || !axis_span(y, yl, yh)) return 0;
            total = (xh - xl + 1) * (yh - yl + 1);
            w = clip_size(width, MAX_SRC_W_DEF);
            h = clip_size(height, MAX_SRC_H_DEF);
            if (w == 0 || h == 0 || xl >= w || yl >= h) return 0;
            if (xh >= w) xh = w - 1;
            if (yh >= h) yh = h - 1;
            return 1;
        endfunction

        function bit predict_lit(bit [9:0] x, bit [9:0] y);
            longint unsigned xl, xh, yl, yh, total, count;
            bit [63:0]       mask;
            count = 0;
            if (source_window(x, y, xl, xh, yl, yh, total)) begin
                mask = ((64'd1 << (xh + 1)) - 64'd1) ^ ((64'd1 << xl) - 64'd1);
                for (int r = int'(yl); r <= int'(yh); r++) begin
                    count += $countones(rows[r] & mask[31:0]);
                end
            end
            return count * 50 > total * 21;
        endfunction

        function int first_blank_row(bit [9:0] x, bit [9:0] y);
            longint unsigned xl, xh, yl, yh, total;
            if (source_window(x, y, xl, xh, yl, yh, total)) begin
                for (int r = int'(yl); r <= int'(yh); r++) begin
                    if (!written[r]) return r;
                end
            end
            return -1;
        endfunction

        function void note_item(t_op op, bit [4:0] ridx, bit [31:0] rbits,
                                bit [9:0] x, bit [9:0] y);
            if (op == OP_WRITE) begin
                rows[ridx]    = rbits;
                written[ridx] = 1'b1;
            end else begin
                expected_lit.push_back(predict_lit(x, y));
            end
        endfunction

        function void check_lit(bit actual);
            bit want;
            if (expected_lit.size() == 0) begin
                $error("lit: expected none, actual %0d", actual);
                fails++;
            end else begin
                want = expected_lit.pop_front();
                if (want != actual) begin
                    $error("lit: expected %0d, actual %0d", want, actual);
                    fails++;
                end
            end
        endfunction

        function int pending();
            return expected_lit.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [20:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_operation = OP_WRITE;
    logic [4:0]  i_row_index = '0;
    logic [31:0] i_row_bits  = '0;
    logic [9:0]  i_out_x     = '0;
    logic [9:0]  i_out_y     = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_lit;

    coverage_scoreboard board;
    bit                 steady;
    int                 stall_left;

    bitmap_area_average_resample_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_out_x     (i_out_x),
        .i_out_y     (i_out_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_lit       (o_lit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [5:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'($urandom_range(33, 63));
            2:       return 6'd32;
            3:       return 6'd1;
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic longint unsigned axis_limit(bit [5:0] n, bit [20:0] inv);
        longint unsigned lim;
        if (inv == 0) return 1023;
        lim = ((longint'(n) + 1) << FRAC_BITS) / inv + 1;
        return (lim > 1023) ? 1023 : lim;
    endfunction

    function automatic bit [9:0] pick_coord(longint unsigned lim);
        if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, int'(lim)));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) board.check_lit(o_lit);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(t_op op, bit [4:0] ridx, bit [31:0] rbits,
                             bit [9:0] x, bit [9:0] y);
        int gap;
        int blank;
        blank = -1;
        if (op == OP_QUERY) blank = board.first_blank_row(x, y);
        if (blank >= 0) begin
            op    = OP_WRITE;
            ridx  = blank[4:0];
            rbits = $urandom;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_row_index <= ridx;
        i_row_bits  <= rbits;
        i_out_x     <= x;
        i_out_y     <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(op, ridx, rbits, x, y);
    endtask

    task automatic query(bit [9:0] x, bit [9:0] y);
        send_item(OP_QUERY, 5'($urandom), 32'($urandom), x, y);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [20:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(bit [5:0] w, bit [5:0] h, bit [20:0] inv);
        drain();
        write_reg(CFG_SRC_WIDTH, 21'(w));
        write_reg(CFG_SRC_HEIGHT, 21'(h));
        write_reg(CFG_INV_SCALE, inv);
        write_reg(CFG_UNUSED_IDX, 21'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        bit [5:0]        w, h;
        bit [20:0]       inv;
        longint unsigned lim_x, lim_y;
        int              h_eff;
        bit [4:0]        ridx;
        bit [31:0]       rbits;
        w = pick_size();
        h = pick_size();
        case ($urandom_range(0, 11))
            0:       inv = 21'd0;
            1:       inv = 21'd1;
            2:       inv = 21'h1F_FFFF;
            3:       inv = 21'h10_0000;
            4:       inv = 21'($urandom);
            5, 6, 7: inv = 21'($urandom_range(21'h0_4000, 21'h1_0000));
            default: inv = 21'($urandom_range(21'h1_0000, 21'h6_0000));
        endcase
        configure(w, h, inv);
        steady = ($urandom_range(0, 3) == 0);
        lim_x  = axis_limit(w, inv);
        lim_y  = axis_limit(h, inv);
        h_eff  = (h > BITMAP_ROWS) ? BITMAP_ROWS : h;
        repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 35) begin
                if (h_eff > 0 && $urandom_range(0, 9) < 7) ridx = 5'($urandom_range(0, h_eff - 1));
                else ridx = 5'($urandom);
                case ($urandom_range(0, 4))
                    0:       rbits = '0;
                    1:       rbits = '1;
                    4:       rbits = $urandom & $urandom & $urandom;
                    default: rbits = $urandom;
                endcase
                send_item(OP_WRITE, ridx, rbits, 10'($urandom), 10'($urandom));
            end else begin
                query(pick_coord(lim_x), pick_coord(lim_y));
            end
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(SRC_WIDTH_RST, SRC_HEIGHT_RST, INV_SCALE_RST);
        send_item(OP_WRITE, 5'd0, 32'h0000_0001, 10'h3FF, 10'h3FF);
        query(10'd0, 10'd0);
        query(10'd1, 10'd0);
        query(10'd0, 10'd1);
        query(10'h3FF, 10'h3FF);
        send_item(OP_WRITE, 5'd0, 32'hFFFF_FFFE, 10'd0, 10'd0);
        send_item(OP_QUERY, 5'h1F, 32'hFFFF_FFFF, 10'd0, 10'd0);

        configure(6'h3F, 6'd2, 21'h1F_FFFF);
        send_item(OP_WRITE, 5'd1, 32'hFFFF_FFFF, 10'd0, 10'd0);
        query(10'd0, 10'd0);
        query(10'd1, 10'd1);
        query(10'h3FF, 10'd0);

        configure(6'd0, 6'd0, 21'h1_0000);
        query(10'd0, 10'd0);

        configure(6'd32, 6'd32, 21'd0);
        query(10'd5, 10'd5);

        configure(6'd32, 6'd32, 21'd1);
        query(10'd0, 10'd0);
        query(10'h3FF, 10'h3FF);

        configure(6'd32, 6'd32, 21'h0_8000);
        send_item(OP_WRITE, 5'h1F, 32'hAAAA_5555, 10'd0, 10'd0);
        query(10'd63, 10'd63);
        query(10'd62, 10'd62);

        repeat (PHASES) random_phase();

        drain();
        if (board.fails == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== bitmap_area_average_resample_unit.f =====
hw/rtl/bwaar_pkg.sv
hw/rtl/bwaar_queue.sv
hw/rtl/bwaar_front.sv
hw/rtl/bwaar_back.sv
hw/rtl/bitmap_area_average_resample_unit.sv
tb/sv/testbench.sv
